### rtl/bbfc_pkg.sv
// Package: shared types and constants for the bounding box frustum cull unit.
`default_nettype none
package bbfc_pkg;
  localparam int CfgIdxW = 2;
  localparam logic [1:0] REG_MIN_X = 2'd0;
  localparam logic [1:0] REG_MAX_X = 2'd1;
  localparam logic [1:0] REG_MIN_Y = 2'd2;
  localparam logic [1:0] REG_MAX_Y = 2'd3;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_MINUS_ONE = -32'sd65536;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
  localparam logic [5:0] ALL_ONES_OC = 6'h3f;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_ROW, ST_DIV, ST_DIVWAIT, ST_CORNER, ST_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

### rtl/bbfc_if.sv
// Interfaces: input item, result item and configuration write channels.
`default_nettype none
interface bbfc_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic               matrix_select;
  logic [3:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] pos_w;
  logic               last_corner;
  modport source (output valid, func, matrix_select, coef_index, coef_value,
                  pos_x, pos_y, pos_z, pos_w, last_corner, input ready);
  modport sink (input valid, func, matrix_select, coef_index, coef_value,
                pos_x, pos_y, pos_z, pos_w, last_corner, output ready);
endinterface

interface bbfc_out_if;
  logic       valid;
  logic       ready;
  logic       box_visible;
  logic       edge_crossing;
  logic [5:0] common_outcode;
  modport source (output valid, box_visible, edge_crossing, common_outcode,
                  input ready);
  modport sink (input valid, box_visible, edge_crossing, common_outcode,
                output ready);
endinterface

interface bbfc_cfg_if;
  logic               valid;
  logic               ready;
  logic [1:0]         index;
  logic signed [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/bbfc_div.sv
// Restoring Q16.16 divider: one quotient bit per cycle, saturating.
`default_nettype none
module bbfc_div
  import bbfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire div_req_t req,
  output div_rsp_t  rsp
);
  // |n|*2^16 needs 48 bits; quotient of 48 bits.
  logic [47:0] dividend;
  logic [47:0] quo;
  logic [32:0] rem;
  logic [31:0] dmag;
  logic        neg;
  logic        busy;
  logic [5:0]  cnt;
  logic        zero_den;
  logic        num_pos;
  logic        num_zero;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic signed [49:0] sq;
  logic        done_q;
  logic signed [31:0] quo_c;

  assign shifted = {rem[31:0], dividend[47]};
  assign diff = shifted - {1'b0, dmag};
  assign rsp = {done_q, quo_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        rem <= '0;
        quo <= '0;
        dividend <= {(req.num[31] ? 32'(-req.num) : 32'(req.num)), 16'd0};
        dmag <= req.den[31] ? 32'(-req.den) : 32'(req.den);
        neg <= req.num[31] ^ req.den[31];
        zero_den <= (req.den == 32'sd0);
        num_pos <= !req.num[31] && (req.num != 32'sd0);
        num_zero <= (req.num == 32'sd0);
      end else if (busy) begin
        dividend <= {dividend[46:0], 1'b0};
        if (!diff[32]) begin
          rem <= diff;
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    sq = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    if (zero_den) begin
      quo_c = num_zero ? 32'sd0 : (num_pos ? SAT_MAX : SAT_MIN);
    end else if (sq > 50'(SAT_MAX)) begin
      quo_c = SAT_MAX;
    end else if (sq < -50'sd2147483648) begin
      quo_c = SAT_MIN;
    end else begin
      quo_c = sq[31:0];
    end
  end
endmodule
`default_nettype wire

### rtl/bounding_box_frustum_cull_unit.sv
// Top level: bounding box frustum cull unit with a shared multiplier and divider.
`default_nettype none
// One item at a time. A corner runs from its accept to the next accept
// through 32 multiply-accumulate steps on the single 32x32 multiplier
// (matrix A then B, one product per cycle), a drain of the read, multiply
// and accumulate pipeline (the row sums are saturated on the way out), then
// the bit-serial divider computes x/w and y/w in turn (each a start, 48
// quotient bits and a done), then the fold step folds the corner into the
// box. The divider sets the rate. The result register holds until taken;
// input is still accepted while it waits, and only a second finished box
// stalls in the fold step until the first is taken. The matrix store is a
// 32-entry memory that reads as undefined until loaded.
module bounding_box_frustum_cull_unit
  import bbfc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  bbfc_in_if.sink    in_ch,
  bbfc_out_if.source out_ch,
  bbfc_cfg_if.sink   cfg
);
  state_t state, state_next;

  logic signed [31:0] mem [32];
  logic signed [31:0] coef_q;
  logic signed [31:0] rmin_x, rmax_x, rmin_y, rmax_y;
  logic signed [31:0] vec [4];
  logic signed [31:0] va [4];
  logic signed [31:0] vb [4];
  logic [4:0]  step;      // read address as {mat, row, col}
  logic        rd_v;      // coefficient read in flight
  logic [4:0]  rd_tag;
  logic        mul_v;     // product in flight
  logic [4:0]  mul_tag;
  logic        row_v;     // row sum complete in acc
  logic [4:0]  row_tag;
  logic signed [49:0] acc;
  logic        last_q;
  logic        div_sel;   // 0 x/w, 1 y/w
  logic signed [31:0] px;
  logic [5:0]  run_oc;
  logic        run_edge;
  logic [3:0]  outside;
  logic [3:0]  outside_next;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic signed [63:0] prod;
  logic signed [47:0] fl;
  logic signed [31:0] sat_acc;
  logic [5:0]  oc_a, oc_b;
  logic        check, vis, corner_go;

  bbfc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == ST_IDLE);

  // Coefficient read: step = {mat, row[1:0], col[1:0]} -> entry mat*16+col*4+row.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && !in_ch.func)
      mem[{in_ch.matrix_select, in_ch.coef_index}] <= in_ch.coef_value;
    coef_q <= mem[{step[4], step[1:0], step[3:2]}];
  end

  // Product from the registered coefficient; floor of >>16 is arithmetic shift.
  always_ff @(posedge clk) prod <= coef_q * vec[rd_tag[1:0]];
  assign fl = prod[63:16];

  always_comb begin
    if (acc > 50'sd2147483647) sat_acc = SAT_MAX;
    else if (acc < -50'sd2147483648) sat_acc = SAT_MIN;
    else sat_acc = acc[31:0];
  end

  function automatic logic [5:0] outc(input logic signed [31:0] o [4]);
    logic signed [32:0] aw;
    logic [5:0] c;
    aw = o[3][31] ? -33'(o[3]) : 33'(o[3]);
    c[0] = 33'(o[0]) > aw;
    c[1] = 33'(o[0]) < -aw;
    c[2] = 33'(o[1]) > aw;
    c[3] = 33'(o[1]) < -aw;
    c[4] = 33'(o[2]) > aw;
    c[5] = 33'(o[2]) < -aw;
    return c;
  endfunction

  assign oc_a = outc(va);
  assign oc_b = outc(vb);
  assign check = !(rmin_x == Q_MINUS_ONE && rmax_x == Q_ONE &&
                   rmin_y == Q_MINUS_ONE && rmax_y == Q_ONE);
  // Flags: bit 0 left, 1 right, 2 bottom, 3 top; drsp.quo holds y/w here.
  assign outside_next = outside & ~{drsp.quo < rmax_y, rmin_y < drsp.quo,
                                    px < rmax_x, rmin_x < px};
  assign vis = ((run_oc & oc_a) == 6'd0) && !(check && (outside_next != 4'd0));
  // Hold the fold step only when a finished box meets a result still waiting.
  assign corner_go = !last_q || !out_ch.valid || out_ch.ready;

  // Pipeline: coefficient read at step s into coef_q, then the product into prod, then the accumulate into acc.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_ch.valid && in_ch.ready && in_ch.func) state_next = ST_MAC;
      ST_MAC:    if (step == 5'd31) state_next = ST_ROW;
      ST_ROW:    if (row_v && row_tag == 5'd31) state_next = ST_DIV;
      ST_DIV:    state_next = ST_DIVWAIT;
      ST_DIVWAIT: if (drsp.done) state_next = div_sel ? ST_CORNER : ST_DIV;
      ST_CORNER: if (corner_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq.start = (state == ST_DIV);
    dreq.num = div_sel ? va[1] : va[0];
    dreq.den = va[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_ch.valid <= 1'b0;
      rmin_x <= Q_MINUS_ONE;
      rmax_x <= Q_ONE;
      rmin_y <= Q_MINUS_ONE;
      rmax_y <= Q_ONE;
      run_oc <= ALL_ONES_OC;
      run_edge <= 1'b0;
      outside <= 4'hf;
      rd_v <= 1'b0;
      mul_v <= 1'b0;
      row_v <= 1'b0;
    end else begin
      state <= state_next;
      // Advance the multiply-accumulate pipeline.
      rd_v <= (state == ST_MAC);
      rd_tag <= step;
      mul_v <= rd_v;
      mul_tag <= rd_tag;
      row_v <= mul_v && (mul_tag[1:0] == 2'd3);
      row_tag <= mul_tag;
      if (mul_v) acc <= (mul_tag[1:0] == 2'd0) ? 50'(fl) : acc + 50'(fl);
      if (row_v) begin
        if (row_tag[4]) vb[row_tag[3:2]] <= sat_acc;
        else va[row_tag[3:2]] <= sat_acc;
      end
      if (state == ST_CORNER && corner_go && last_q) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MIN_X: rmin_x <= cfg.data;
          REG_MAX_X: rmax_x <= cfg.data;
          REG_MIN_Y: rmin_y <= cfg.data;
          REG_MAX_Y: rmax_y <= cfg.data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          vec[0] <= in_ch.pos_x;
          vec[1] <= in_ch.pos_y;
          vec[2] <= in_ch.pos_z;
          vec[3] <= in_ch.pos_w;
          last_q <= in_ch.last_corner;
          step <= 5'd0;
          div_sel <= 1'b0;
        end
        ST_MAC: begin
          step <= step + 5'd1;
        end
        ST_DIVWAIT: begin
          if (drsp.done) begin
            if (!div_sel) px <= drsp.quo;
            div_sel <= 1'b1;
          end
        end
        ST_CORNER: begin
          if (corner_go) begin
            if (last_q) begin
              out_ch.box_visible <= vis;
              out_ch.edge_crossing <= vis && (run_edge || oc_b != 6'd0);
              out_ch.common_outcode <= run_oc & oc_a;
              run_oc <= ALL_ONES_OC;
              run_edge <= 1'b0;
              outside <= 4'hf;
            end else begin
              outside <= outside_next;
              run_oc <= run_oc & oc_a;
              if (oc_b != 6'd0) run_edge <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
